FILE: rtl/esd_pkg.sv
// esd_pkg: shared types, codes and character-class helpers for the
// escape sequence decoder. No dependencies.

package esd_pkg;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_ESC   = 2'd1,
    PH_NUM   = 2'd2,
    PH_DIGIT = 2'd3
  } phase_e;

  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_NINE      = 8'd57;
  localparam logic [7:0] CH_SEVEN     = 8'd55;
  localparam logic [7:0] CH_UC_A      = 8'd65;
  localparam logic [7:0] CH_UC_F      = 8'd70;
  localparam logic [7:0] CH_LC_A      = 8'd97;
  localparam logic [7:0] CH_LC_F      = 8'd102;
  localparam logic [7:0] CH_A         = 8'd97;
  localparam logic [7:0] CH_S         = 8'd115;
  localparam logic [7:0] CH_N         = 8'd110;
  localparam logic [7:0] CH_R         = 8'd114;
  localparam logic [7:0] CH_T         = 8'd116;
  localparam logic [7:0] CH_V         = 8'd118;
  localparam logic [7:0] CH_X         = 8'd120;
  localparam logic [7:0] CH_ONE       = 8'd49;
  localparam logic [7:0] CH_TWO       = 8'd50;
  localparam logic [7:0] CH_THREE     = 8'd51;

  localparam logic [7:0] BYTE_BEL   = 8'd7;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_VT    = 8'd11;

  localparam int unsigned MaxBeats = 3;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] letter;
    logic [7:0] digit;
  } esd_state_t;

  typedef struct packed {
    logic [1:0]           cnt;
    logic [2:0][7:0]      bytes;
  } esd_res_t;

  function automatic logic is_hex_class(logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UC_A && b <= CH_UC_F) ||
           (b >= CH_LC_A && b <= CH_LC_F);
  endfunction

  function automatic logic is_octal(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_SEVEN;
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] b);
    return b[6] ? (b[3:0] + 4'd9) : b[3:0];
  endfunction

endpackage

FILE: rtl/esd_decode.sv
// esd_decode: combinational decode of one input byte against the held
// escape state; gives the next state and up to three output bytes.
// Depends on esd_pkg.

module esd_decode (
  input  esd_pkg::esd_state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output esd_pkg::esd_state_t state_o,
  output esd_pkg::esd_res_t   res_o
);

  function automatic esd_pkg::esd_res_t push(esd_pkg::esd_res_t r, logic [7:0] v);
    esd_pkg::esd_res_t t;
    t = r;
    t.bytes[r.cnt] = v;
    t.cnt = r.cnt + 2'd1;
    return t;
  endfunction

  // plain-text handling of the current byte, appended after any prefix
  function automatic esd_pkg::esd_res_t plain(esd_pkg::esd_res_t r, logic [7:0] b,
                                              logic last);
    esd_pkg::esd_res_t t;
    t = r;
    if (b != esd_pkg::CH_BACKSLASH) begin
      t = push(r, b);
    end else if (last) begin
      t = push(r, esd_pkg::CH_BACKSLASH);
    end
    return t;
  endfunction

  logic       hex_ok;
  logic       oct_ok;
  logic       num_ok;
  logic [7:0] num_val;
  logic       is_numeric_letter;

  assign is_numeric_letter = (byte_i == esd_pkg::CH_X) || (byte_i == esd_pkg::CH_ZERO) ||
                             (byte_i == esd_pkg::CH_ONE) || (byte_i == esd_pkg::CH_TWO) ||
                             (byte_i == esd_pkg::CH_THREE);
  assign hex_ok  = esd_pkg::is_hex_class(byte_i);
  assign oct_ok  = esd_pkg::is_octal(state_i.digit) && esd_pkg::is_octal(byte_i);
  assign num_ok  = hex_ok && ((state_i.letter == esd_pkg::CH_X) || oct_ok);
  assign num_val = (state_i.letter == esd_pkg::CH_X) ?
                   {esd_pkg::hex_nibble(state_i.digit), esd_pkg::hex_nibble(byte_i)} :
                   {state_i.letter[1:0], state_i.digit[2:0], byte_i[2:0]};

  // next state
  always_comb begin
    state_o = state_i;
    state_o.phase = esd_pkg::PH_TEXT;
    case (state_i.phase)
      esd_pkg::PH_TEXT: begin
        if (byte_i == esd_pkg::CH_BACKSLASH && !last_i) state_o.phase = esd_pkg::PH_ESC;
      end
      esd_pkg::PH_ESC: begin
        if (is_numeric_letter && !last_i) begin
          state_o.phase  = esd_pkg::PH_NUM;
          state_o.letter = byte_i;
        end
      end
      esd_pkg::PH_NUM: begin
        if (hex_ok && !last_i) begin
          state_o.phase = esd_pkg::PH_DIGIT;
          state_o.digit = byte_i;
        end else if (byte_i == esd_pkg::CH_BACKSLASH && !last_i) begin
          state_o.phase = esd_pkg::PH_ESC;
        end
      end
      esd_pkg::PH_DIGIT: begin
        if (!num_ok && byte_i == esd_pkg::CH_BACKSLASH && !last_i) begin
          state_o.phase = esd_pkg::PH_ESC;
        end
      end
      default: state_o.phase = esd_pkg::PH_TEXT;
    endcase
    if (last_i) begin
      state_o = '0;
    end
  end

  // output bytes
  always_comb begin
    res_o = '0;
    case (state_i.phase)
      esd_pkg::PH_TEXT: res_o = plain(res_o, byte_i, last_i);
      esd_pkg::PH_ESC: begin
        case (byte_i)
          esd_pkg::CH_BACKSLASH: res_o = push(res_o, esd_pkg::CH_BACKSLASH);
          esd_pkg::CH_A:         res_o = push(res_o, esd_pkg::BYTE_BEL);
          esd_pkg::CH_S:         res_o = push(res_o, esd_pkg::BYTE_SPACE);
          esd_pkg::CH_N:         res_o = push(res_o, esd_pkg::BYTE_LF);
          esd_pkg::CH_R:         res_o = push(res_o, esd_pkg::BYTE_CR);
          esd_pkg::CH_T:         res_o = push(res_o, esd_pkg::BYTE_TAB);
          esd_pkg::CH_V:         res_o = push(res_o, esd_pkg::BYTE_VT);
          default: begin
            if (is_numeric_letter) begin
              if (last_i) res_o = push(res_o, byte_i);
            end else begin
              res_o = push(res_o, esd_pkg::CH_BACKSLASH);
              res_o = push(res_o, byte_i);
            end
          end
        endcase
      end
      esd_pkg::PH_NUM: begin
        if (!(hex_ok && !last_i)) begin
          res_o = push(res_o, state_i.letter);
          res_o = plain(res_o, byte_i, last_i);
        end
      end
      esd_pkg::PH_DIGIT: begin
        if (num_ok) begin
          res_o = push(res_o, num_val);
        end else begin
          res_o = push(res_o, state_i.letter);
          res_o = push(res_o, state_i.digit);
          res_o = plain(res_o, byte_i, last_i);
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

FILE: rtl/escape_sequence_decoder_top.sv
// escape_sequence_decoder_top: backslash escape decoder, byte in, bytes out.
// Instantiates esd_decode; uses esd_pkg.
//
//   channel | direction | beat           | handshake
//   in      | input     | in_byte, last  | in_valid_i / in_stall_o
//   out     | output    | out_byte, last | out_valid_o / out_stall_i
//
// One input beat per cycle when each byte decodes to at most one output and the output is not stalled.
// A beat giving two or three bytes holds the input while the result buffer
// drains, one beat per cycle while the output is not stalled.
// Input is taken when the buffer is empty or its last beat leaves this cycle.
// Reset empties the buffer and returns to plain text. No clearing pass.

module escape_sequence_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  esd_pkg::esd_state_t state_q, state_d;
  esd_pkg::esd_res_t   res;
  logic [1:0]          cnt_q, cnt_d;
  logic [2:0][7:0]     buf_q, buf_d;
  logic                last_q, last_d;
  logic                in_acc;
  logic                out_acc;

  esd_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .state_o (state_d),
    .res_o   (res)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_byte_o  = buf_q[0];
  assign out_last_o  = last_q && (cnt_q == 2'd1);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i));
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_d  = cnt_q;
    buf_d  = buf_q;
    last_d = last_q;
    if (in_acc) begin
      cnt_d  = res.cnt;
      buf_d  = res.bytes;
      last_d = in_last_i;
    end else if (out_acc) begin
      cnt_d  = cnt_q - 2'd1;
      buf_d  = {8'd0, buf_q[2], buf_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= 2'd0;
      last_q  <= 1'b0;
    end else begin
      if (in_acc) state_q <= state_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(esd_pkg::MaxBeats))
    else $error("result count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_acc))
    else $error("input taken over pending results");

  a_last_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> (cnt_q != 2'd0) && last_q)
    else $error("final beat produced no output");

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> state_q.phase == esd_pkg::PH_TEXT)
    else $error("state not cleared after final beat");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking bench for escape_sequence_decoder_top: directed and random escaped strings
// go in, and an unescape scoreboard predicts each decoded beat and checks it as it leaves.
// Depends on esd_pkg and the decoder RTL only.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TargetBeats   = 320;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned WatchdogLimit = 1000;

  class unescape_scoreboard;
    esd_pkg::phase_e phase;
    logic [7:0]      letter;
    logic [7:0]      digit;
    logic [7:0]      decoded[$];
    logic [8:0]      pending[$];
    int unsigned     errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase  = esd_pkg::PH_TEXT;
      letter = '0;
      digit  = '0;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function bit hex_char(logic [7:0] b);
      return (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd70) ||
             (b >= 8'd97 && b <= 8'd102);
    endfunction

    function bit octal_char(logic [7:0] b);
      return b >= 8'd48 && b <= 8'd55;
    endfunction

    function logic [3:0] nibble_of(logic [7:0] b);
      logic [7:0] v;
      if (b <= 8'd57) v = b - 8'd48;
      else if (b <= 8'd70) v = b - 8'd55;
      else v = b - 8'd87;
      return v[3:0];
    endfunction

    function void text_byte(logic [7:0] b, logic l);
      if (b == esd_pkg::CH_BACKSLASH) begin
        if (l) begin
          decoded.push_back(esd_pkg::CH_BACKSLASH);
          phase = esd_pkg::PH_TEXT;
        end else begin
          phase = esd_pkg::PH_ESC;
        end
      end else begin
        decoded.push_back(b);
        phase = esd_pkg::PH_TEXT;
      end
    endfunction

    function void note_input(logic [7:0] b, logic l);
      bit         ok;
      logic [7:0] v;
      ok = 1'b0;
      v  = '0;
      decoded.delete();
      case (phase)
        esd_pkg::PH_TEXT: text_byte(b, l);
        esd_pkg::PH_ESC: begin
          phase = esd_pkg::PH_TEXT;
          case (b)
            esd_pkg::CH_BACKSLASH: decoded.push_back(esd_pkg::CH_BACKSLASH);
            esd_pkg::CH_A:         decoded.push_back(esd_pkg::BYTE_BEL);
            esd_pkg::CH_S:         decoded.push_back(esd_pkg::BYTE_SPACE);
            esd_pkg::CH_N:         decoded.push_back(esd_pkg::BYTE_LF);
            esd_pkg::CH_R:         decoded.push_back(esd_pkg::BYTE_CR);
            esd_pkg::CH_T:         decoded.push_back(esd_pkg::BYTE_TAB);
            esd_pkg::CH_V:         decoded.push_back(esd_pkg::BYTE_VT);
            esd_pkg::CH_X, esd_pkg::CH_ZERO, esd_pkg::CH_ONE, esd_pkg::CH_TWO,
            esd_pkg::CH_THREE: begin
              if (l) begin
                decoded.push_back(b);
              end else begin
                letter = b;
                phase  = esd_pkg::PH_NUM;
              end
            end
            default: begin
              decoded.push_back(esd_pkg::CH_BACKSLASH);
              decoded.push_back(b);
            end
          endcase
        end
        esd_pkg::PH_NUM: begin
          if (hex_char(b) && !l) begin
            digit = b;
            phase = esd_pkg::PH_DIGIT;
          end else begin
            decoded.push_back(letter);
            text_byte(b, l);
          end
        end
        default: begin
          if (hex_char(b)) begin
            if (letter == esd_pkg::CH_X) begin
              ok = 1'b1;
              v  = {nibble_of(digit), nibble_of(b)};
            end else if (octal_char(digit) && octal_char(b)) begin
              ok = 1'b1;
              v  = {letter[1:0], digit[2:0], b[2:0]};
            end
          end
          if (ok) begin
            decoded.push_back(v);
            phase = esd_pkg::PH_TEXT;
          end else begin
            decoded.push_back(letter);
            decoded.push_back(digit);
            text_byte(b, l);
          end
        end
      endcase
      foreach (decoded[i]) pending.push_back({l && (i == decoded.size() - 1), decoded[i]});
      if (l) clear_state();
    endfunction

    function void check_result(logic [7:0] b, logic l);
      logic [8:0] want;
      if (pending.size() == 0) begin
        $error("unexpected output beat: out_byte %0d out_last %0d", b, l);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (b !== want[7:0]) begin
        $error("out_byte mismatch: expected %0d, got %0d", want[7:0], b);
        errors++;
      end
      if (l !== want[8]) begin
        $error("out_last mismatch: expected %0d, got %0d", want[8], l);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;

  unescape_scoreboard sb;
  logic [7:0]         text[$];
  int unsigned        beats_sent;
  int unsigned        idle_cycles;
  bit                 quiet;
  bit                 hold_req;

  escape_sequence_decoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_beat(input logic [7:0] b, input logic l);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_beat(text[i], i == text.size() - 1);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_digit();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(48 + k);
    if (k < 16) return 8'(55 + k);
    return 8'(81 + k);
  endfunction

  function automatic logic [7:0] numeric_letter();
    case ($urandom_range(0, 4))
      0:       return esd_pkg::CH_X;
      1:       return esd_pkg::CH_ZERO;
      2:       return esd_pkg::CH_ONE;
      3:       return esd_pkg::CH_TWO;
      default: return esd_pkg::CH_THREE;
    endcase
  endfunction

  function automatic logic [7:0] simple_letter();
    case ($urandom_range(0, 6))
      0:       return esd_pkg::CH_BACKSLASH;
      1:       return esd_pkg::CH_A;
      2:       return esd_pkg::CH_S;
      3:       return esd_pkg::CH_N;
      4:       return esd_pkg::CH_R;
      5:       return esd_pkg::CH_T;
      default: return esd_pkg::CH_V;
    endcase
  endfunction

  // well-formed escapes with random content, plus broken ones and noise
  task automatic build_random_string();
    int unsigned kind;
    int unsigned tokens;
    text.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        text.push_back(any_byte());
      end else if (kind < 50) begin
        text.push_back(esd_pkg::CH_BACKSLASH);
        text.push_back(simple_letter());
      end else if (kind < 65) begin
        text.push_back(esd_pkg::CH_BACKSLASH);
        text.push_back(esd_pkg::CH_X);
        text.push_back(hex_digit());
        text.push_back(hex_digit());
      end else if (kind < 78) begin
        text.push_back(esd_pkg::CH_BACKSLASH);
        text.push_back(8'(48 + $urandom_range(0, 3)));
        text.push_back(8'(48 + $urandom_range(0, 7)));
        text.push_back(8'(48 + $urandom_range(0, 7)));
      end else if (kind < 90) begin
        text.push_back(esd_pkg::CH_BACKSLASH);
        text.push_back(numeric_letter());
        text.push_back($urandom_range(0, 1) ? hex_digit() : any_byte());
        if ($urandom_range(0, 1)) text.push_back(any_byte());
      end else begin
        text.push_back(esd_pkg::CH_BACKSLASH);
        text.push_back(any_byte());
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_byte, in_last);
      if (out_valid && !out_stall) sb.check_result(out_byte, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    bit held;
    bit paused;
    sb          = new();
    held        = 1'b0;
    paused      = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    beats_sent  = 0;
    idle_cycles = 0;
    in_valid    = 1'b0;
    in_byte     = '0;
    in_last     = 1'b0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hex escape giving the top byte
    text = '{esd_pkg::CH_BACKSLASH, esd_pkg::CH_X, 8'd70, 8'd102};
    send_text();
    // octal escape giving the top byte
    text = '{esd_pkg::CH_BACKSLASH, esd_pkg::CH_THREE, 8'd55, 8'd55};
    send_text();
    // octal with a non-octal digit, then a trailing backslash: three bytes at once
    text = '{esd_pkg::CH_BACKSLASH, esd_pkg::CH_ZERO, 8'd56, esd_pkg::CH_BACKSLASH};
    send_text();
    // unknown escape letter, then the top byte value
    text = '{esd_pkg::CH_BACKSLASH, 8'd113, 8'd255};
    send_text();
    // string ending right after a numeric letter
    text = '{esd_pkg::CH_BACKSLASH, esd_pkg::CH_THREE};
    send_text();
    // zero byte as data, then a trailing backslash
    text = '{8'd0, esd_pkg::CH_BACKSLASH};
    send_text();
    // string ending after one hex digit
    text = '{esd_pkg::CH_BACKSLASH, esd_pkg::CH_X, 8'd52};
    send_text();
    // broken hex escape restarting a fresh escape
    text = '{esd_pkg::CH_BACKSLASH, esd_pkg::CH_X, 8'd103, esd_pkg::CH_BACKSLASH,
             esd_pkg::CH_N};
    send_text();

    while (beats_sent < TargetBeats) begin
      if (!held && beats_sent >= 90) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && beats_sent >= 180) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
      end
      quiet = (beats_sent >= 220) && (beats_sent < 290);
      build_random_string();
      send_text();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
